// File: hw/rtl/fhcc_pkg.sv
`timescale 1ns / 1ps
package fhcc_pkg;

  typedef struct packed {
    logic [7:0]  soil_moisture;
    logic [7:0]  light_level;
    logic signed [11:0] temperature;
    logic [15:0] co2_level;
    logic        is_day;
  } in_item_t;

  typedef struct packed {
    logic       pump_on;
    logic       led_on;
    logic       fan_run;
    logic [6:0] fan_pct;
    logic [7:0] shade_angle;
    logic       shade_move;
  } out_item_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegAutoEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSoil = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLight = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTemp = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCo2Day = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCo2Night = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFanMax = 3'd6;

  localparam logic [7:0] PctMax = 8'd100;
  localparam logic [7:0] ShadeAngleOn = 8'd135;

  // Degree as an exact fraction; numerator never exceeds denominator.
  localparam int unsigned FracW = 18;
  typedef struct packed {
    logic [FracW-1:0] n;
    logic [FracW-1:0] d;
  } frac_t;

  // Operand pairs for the shared multiplier and its compare.
  typedef struct packed {
    logic [FracW-1:0] a;
    logic [FracW-1:0] b;
    logic [FracW-1:0] c;
    logic [FracW-1:0] e;
  } mul_req_t;

endpackage

// File: hw/rtl/fhcc_degree.sv
`timescale 1ns / 1ps
module fhcc_degree
  import fhcc_pkg::*;
(
  input  logic               upper_i,
  input  logic signed [17:0] x_i,
  input  logic signed [17:0] lo_i,
  input  logic signed [17:0] hi_i,
  output frac_t              deg_o
);

  logic signed [17:0] num;

  always_comb begin
    num = 18'sd0;
    deg_o.n = '0;
    deg_o.d = FracW'(1);
    if (lo_i >= hi_i) begin
      deg_o.n = FracW'(upper_i ? (x_i >= lo_i) : (x_i <= lo_i));
    end else if (x_i <= lo_i) begin
      deg_o.n = FracW'(!upper_i);
    end else if (x_i >= hi_i) begin
      deg_o.n = FracW'(upper_i);
    end else begin
      num = upper_i ? (x_i - lo_i) : (hi_i - x_i);
      deg_o.n = FracW'(num);
      deg_o.d = FracW'(hi_i - lo_i);
    end
  end

endmodule

// File: hw/rtl/fhcc_mul_unit.sv
`timescale 1ns / 1ps
module fhcc_mul_unit
  import fhcc_pkg::*;
(
  input  logic     clk_i,
  input  mul_req_t req_i,
  output logic     lt_o,
  output logic     le_o,
  output logic [2*FracW-1:0] p_o
);

  // Registered a*b and c*e, compared after the register.
  logic [2*FracW-1:0] p0_q, p1_q;

  always_ff @(posedge clk_i) begin
    p0_q <= req_i.a * req_i.b;
    p1_q <= req_i.c * req_i.e;
  end

  assign lt_o = p0_q < p1_q;
  assign le_o = p0_q <= p1_q;
  assign p_o  = p0_q;

endmodule

// File: hw/rtl/fhcc_divider.sv
`timescale 1ns / 1ps
module fhcc_divider
  import fhcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2*FracW-1:0] num_i,
  input  logic [FracW:0]     den_i,
  output logic               done_o,
  output logic [6:0]         quo_o
);

  // Restoring division, one quotient bit per cycle; quotient fits in 7 bits.
  localparam int unsigned Bits = 7;
  logic [2*FracW-1:0] rem_q, rem_d;
  logic [Bits-1:0]    quo_q, quo_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [2*FracW+Bits:0] shd;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shd = '0;
    if (start_i) begin
      rem_d = num_i; quo_d = '0; cnt_d = 3'(Bits - 1); busy_d = 1'b1;
    end else if (busy_q) begin
      shd = {{(Bits+1){1'b0}}, 36'(den_i)} << cnt_q;
      if ({{(Bits+1){1'b0}}, rem_q} >= shd) begin
        rem_d = rem_q - shd[2*FracW-1:0];
        quo_d = quo_q | (Bits'(1) << cnt_q);
      end
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hw/rtl/fuzzy_hysteresis_climate_controller_top.sv
`timescale 1ns / 1ps
// A daytime tick also runs the shade compares, which a night tick skips.
// The input stalls from an accepted tick until its result is taken at the output.
// One shared multiplier pair runs every degree compare, and an iterative 7-bit
// divider then computes the fan speed.
// A disabled tick is accepted and gives no result.
// Reset (asynchronous, active low) clears the states and top-level registers; fan max is 100.
module fuzzy_hysteresis_climate_controller_top
  import fhcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_PUMPH, S_PUMPL, S_LEDH, S_LEDL, S_TC, S_FANH, S_FANL, S_LT, S_SHH, S_SHL,
    S_DIV, S_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic auto_q;
  logic [15:0] soil_q, light_q;
  logic [31:0] temp_q, cday_q, cnight_q;
  logic [6:0] fmax_q;
  logic pump_q, led_q, fan_q, shade_q, was_q;
  in_item_t it_q;
  out_item_t out_q;
  frac_t tg_q, cg_q, need_q, sg_q;
  logic need_shade_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q <= 1'b0; soil_q <= '0; light_q <= '0; temp_q <= '0;
      cday_q <= '0; cnight_q <= '0; fmax_q <= 7'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAutoEnable: auto_q <= cfg_data_i[0];
        RegSoil:       soil_q <= cfg_data_i[15:0];
        RegLight:      light_q <= cfg_data_i[15:0];
        RegTemp:       temp_q <= cfg_data_i;
        RegCo2Day:     cday_q <= cfg_data_i;
        RegCo2Night:   cnight_q <= cfg_data_i;
        RegFanMax:     fmax_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  function automatic logic [7:0] clamp(input logic [7:0] v);
    return (v > PctMax) ? PctMax : v;
  endfunction

  logic [7:0] s_a, s_b, s_on, s_off, l_a, l_b, l_on, l_off;
  logic signed [15:0] t_a, t_b, t_hot, t_cool;
  logic [31:0] cw;
  logic [15:0] c_on, c_off;
  logic [6:0] maxsp;
  logic signed [17:0] xs, xl, xt, xc;

  always_comb begin
    s_a = clamp(soil_q[7:0]); s_b = clamp(soil_q[15:8]);
    s_on = (s_a > s_b) ? s_b : s_a; s_off = (s_a > s_b) ? s_a : s_b;
    l_a = clamp(light_q[7:0]); l_b = clamp(light_q[15:8]);
    l_on = (l_a > l_b) ? l_b : l_a; l_off = (l_a > l_b) ? l_a : l_b;
    t_a = temp_q[15:0]; t_b = temp_q[31:16];
    t_hot = (t_b > t_a) ? t_b : t_a; t_cool = (t_b > t_a) ? t_a : t_b;
    cw = it_q.is_day ? cday_q : cnight_q;
    c_on = (cw[31:16] > cw[15:0]) ? cw[31:16] : cw[15:0];
    c_off = (cw[31:16] > cw[15:0]) ? cw[15:0] : cw[31:16];
    maxsp = (fmax_q > 7'd100) ? 7'd100 : fmax_q;
    xs = {10'd0, it_q.soil_moisture};
    xl = {10'd0, it_q.light_level};
    xt = 18'(it_q.temperature);
    xc = {2'd0, it_q.co2_level};
  end

  frac_t ds, dl, dt, dc, dlu;
  fhcc_degree u_ds (.upper_i(1'b0), .x_i(xs), .lo_i({10'd0, s_on}), .hi_i({10'd0, s_off}),
                    .deg_o(ds));
  fhcc_degree u_dl (.upper_i(1'b0), .x_i(xl), .lo_i({10'd0, l_on}), .hi_i({10'd0, l_off}),
                    .deg_o(dl));
  fhcc_degree u_dlu (.upper_i(1'b1), .x_i(xl), .lo_i({10'd0, l_on}),
                     .hi_i({10'd0, l_off}), .deg_o(dlu));
  fhcc_degree u_dt (.upper_i(1'b1), .x_i(xt), .lo_i(18'(t_cool)), .hi_i(18'(t_hot)),
                    .deg_o(dt));
  fhcc_degree u_dc (.upper_i(1'b1), .x_i(xc), .lo_i({2'd0, c_off}), .hi_i({2'd0, c_on}),
                    .deg_o(dc));

  // Shared multiplier: one phase issues, next phase reads the compare.
  mul_req_t req;
  logic lt, le, phase_q;
  logic [2*FracW-1:0] prod;
  frac_t hg;
  logic hi_ok_q, hyst_cur, hyst_new;

  always_comb begin
    unique case (state_q)
      S_PUMPH, S_PUMPL: hg = ds;
      S_LEDH, S_LEDL:   hg = dl;
      S_SHH, S_SHL:     hg = sg_q;
      default: hg = need_q;
    endcase
    req = '0;
    unique case (state_q)
      S_TC: req = '{a: tg_q.n, b: cg_q.d, c: cg_q.n, e: tg_q.d};
      S_LT: req = '{a: dlu.n, b: tg_q.d, c: tg_q.n, e: dlu.d};
      S_PUMPH, S_PUMPL, S_LEDH, S_LEDL, S_FANH, S_FANL, S_SHH, S_SHL: begin
        req.a = FracW'(5); req.b = hg.n; req.e = hg.d;
        req.c = (state_q == S_PUMPL || state_q == S_LEDL || state_q == S_FANL ||
                 state_q == S_SHL) ? FracW'(2) : FracW'(3);
      end
      S_DIV: req = '{a: need_q.n, b: FracW'(2 * maxsp), c: '0, e: '0};
      default: req = '0;
    endcase
    unique case (state_q)
      S_PUMPL: hyst_cur = pump_q;
      S_LEDL:  hyst_cur = led_q;
      S_FANL:  hyst_cur = fan_q;
      default: hyst_cur = shade_q;
    endcase
    hyst_new = hi_ok_q ? 1'b1 : (le ? 1'b0 : hyst_cur);
  end

  fhcc_mul_unit u_mul (.clk_i(clk_i), .req_i(req), .lt_o(lt), .le_o(le), .p_o(prod));

  logic div_start, div_done;
  logic [6:0] quo;
  fhcc_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
                      .num_i(prod + {{FracW{1'b0}}, need_q.d}),
                      .den_i({need_q.d, 1'b0}), .done_o(div_done), .quo_o(quo));

  logic [6:0] speed;

  always_comb begin
    if (need_q.n == '0) speed = 7'd0;
    else if (need_q.n >= need_q.d) speed = maxsp;
    else speed = quo;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign div_start = (state_q == S_DIV) && phase_q;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= 1'b0;
      pump_q <= 1'b0; led_q <= 1'b0; fan_q <= 1'b0; shade_q <= 1'b0; was_q <= 1'b0;
      need_shade_q <= 1'b0; hi_ok_q <= 1'b0;
      it_q <= '0; out_q <= '0; tg_q <= '0; cg_q <= '0; need_q <= '0; sg_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          it_q <= in_data_i; phase_q <= 1'b0;
          state_q <= auto_q ? S_PUMPH : S_IDLE;
          if (!auto_q) was_q <= 1'b0;
        end
        S_PUMPH: begin
          if (!phase_q) begin
            phase_q <= 1'b1;
            tg_q <= dt; cg_q <= dc;
            if (!was_q) begin
              pump_q <= (xs <= {10'd0, s_on});
              led_q <= (xl <= {10'd0, l_on});
              fan_q <= (xt >= 18'(t_hot)) || (xc >= {2'd0, c_on});
              shade_q <= it_q.is_day && (xl >= {10'd0, l_off}) && (xt >= 18'(t_hot));
              was_q <= 1'b1;
            end
          end else begin
            hi_ok_q <= !lt; phase_q <= 1'b0; state_q <= S_PUMPL;
          end
        end
        S_LEDH, S_FANH, S_SHH: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            hi_ok_q <= !lt; phase_q <= 1'b0;
            state_q <= (state_q == S_LEDH) ? S_LEDL :
                       ((state_q == S_FANH) ? S_FANL : S_SHL);
          end
        end
        S_PUMPL: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            pump_q <= hyst_new; phase_q <= 1'b0; state_q <= S_LEDH;
          end
        end
        S_LEDL: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            led_q <= hyst_new; phase_q <= 1'b0; state_q <= S_TC;
          end
        end
        S_FANL: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            fan_q <= hyst_new; phase_q <= 1'b0; state_q <= S_LT;
          end
        end
        S_SHL: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            need_shade_q <= hyst_new; phase_q <= 1'b0; state_q <= S_DIV;
          end
        end
        S_TC: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            need_q <= lt ? cg_q : tg_q;
            phase_q <= 1'b0; state_q <= S_FANH;
          end
        end
        S_LT: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            sg_q <= lt ? dlu : tg_q;
            phase_q <= 1'b0;
            need_shade_q <= 1'b0;
            state_q <= it_q.is_day ? S_SHH : S_DIV;
          end
        end
        S_DIV: begin
          if (!phase_q) phase_q <= 1'b1;
          else begin
            phase_q <= 1'b0; state_q <= S_WAIT;
          end
        end
        S_WAIT: if (div_done) begin
          out_q.pump_on <= pump_q;
          out_q.led_on <= led_q;
          out_q.fan_run <= fan_q && (speed != 7'd0);
          out_q.fan_pct <= speed;
          out_q.shade_angle <= need_shade_q ? ShadeAngleOn : 8'd0;
          out_q.shade_move <= need_shade_q != shade_q;
          shade_q <= need_shade_q;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/fhcc_checker.sv
`timescale 1ns / 1ps
module fhcc_checker
  import fhcc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> in_stall_i)
    else $error("input open while result pending");

  a_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.shade_angle == 8'd0 ||
                     out_data_i.shade_angle == ShadeAngleOn))
    else $error("bad shade angle");

  a_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.fan_pct <= 7'd100 &&
                    (!out_data_i.fan_run || out_data_i.fan_pct != 7'd0))
    else $error("bad fan speed");

endmodule

bind fuzzy_hysteresis_climate_controller_top fhcc_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_i(in_stall_o),
  .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_data_i(out_data_o)
);
